// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hw/rtl/wet_pkg.sv -----
// Package with types and codes of the wait event table.
package wet_pkg;
  localparam logic [2:0] ACT_ACQUIRE = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_PARK = 3'd2;
  localparam logic [2:0] ACT_UNPARK = 3'd3;
  localparam logic [2:0] ACT_NOT_READY = 3'd4;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_TOKEN = 3'd1;
  localparam logic [2:0] ST_READY = 3'd2;
  localparam logic [2:0] ST_NO_SLOT = 3'd3;
  localparam logic [2:0] ST_NO_NODE = 3'd4;
  localparam int MAX_WAKE = 32;

  typedef struct packed {
    logic load;
    logic do_acquire;
    logic do_release_slot;
    logic do_park;
    logic do_unpark_head;
    logic do_not_ready;
    logic walk_free;
    logic walk_emit;
    logic walk_done;
    logic emit_single;
    logic [2:0] emit_status;
  } wet_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic token_ok;
    logic slot_ready;
    logic waiters_zero;
    logic waiters_full;
    logic slot_avail;
    logic node_avail;
    logic walk_last;
  } wet_stat_t;
endpackage

// ----- hw/rtl/wait_event_table_unit.sv -----
// Top level of the wait event table.
// A transfer's single result is registered in the decode state, and unpark's results in the wake walk;
// busy stays high until the controller is back in idle, and only then is the next transfer accepted.
// Release and unpark walk the waiter list one node per cycle.
// Unpark gives one result per waiter on consecutive cycles; the receiver cannot stall.
// Synchronous active-low reset empties all slots and node stacks at once.
module wait_event_table_unit import wet_pkg::*; #(
  parameter int SLOT_COUNT = 16,
  parameter int NODE_COUNT = 32,
  parameter int GEN_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [2:0] in_action,
  input  logic [3:0] in_token_slot,
  input  logic [15:0] in_token_generation,
  input  logic [15:0] in_waiter_id,
  output logic out_valid,
  output logic [2:0] out_status,
  output logic [3:0] out_slot,
  output logic [15:0] out_generation,
  output logic [15:0] out_woken_id,
  output logic out_woken_valid,
  output logic [5:0] out_woken_count,
  output logic out_last
);
  wet_cmd_t cmd;
  wet_stat_t stat;

  wet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  wet_datapath #(
    .SLOT_COUNT(SLOT_COUNT), .NODE_COUNT(NODE_COUNT), .GEN_BITS(GEN_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_action(in_action), .in_token_slot(in_token_slot),
    .in_token_generation(in_token_generation), .in_waiter_id(in_waiter_id),
    .cmd(cmd), .stat(stat), .out_valid(out_valid), .out_status(out_status),
    .out_slot(out_slot), .out_generation(out_generation), .out_woken_id(out_woken_id),
    .out_woken_valid(out_woken_valid), .out_woken_count(out_woken_count),
    .out_last(out_last)
  );
endmodule

// ----- hw/rtl/wet_datapath.sv -----
// Datapath of the wait event table: slot tables, node memories and stacks.
module wet_datapath import wet_pkg::*; #(
  parameter int SLOT_COUNT = 16,
  parameter int NODE_COUNT = 32,
  parameter int GEN_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [2:0] in_action,
  input  logic [3:0] in_token_slot,
  input  logic [15:0] in_token_generation,
  input  logic [15:0] in_waiter_id,
  input  wet_cmd_t cmd,
  output wet_stat_t stat,
  output logic out_valid,
  output logic [2:0] out_status,
  output logic [3:0] out_slot,
  output logic [15:0] out_generation,
  output logic [15:0] out_woken_id,
  output logic out_woken_valid,
  output logic [5:0] out_woken_count,
  output logic out_last
);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SCW = $clog2(SLOT_COUNT + 1);
  localparam int NCW = $clog2(NODE_COUNT + 1);

  logic [SLOT_COUNT-1:0] in_use_r, ready_r;
  logic [GEN_BITS-1:0] gen_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] gen_touched_r;
  logic [NW-1:0] head_r [SLOT_COUNT];
  logic [NW-1:0] tail_r [SLOT_COUNT];
  logic [5:0] waiters_r [SLOT_COUNT];
  logic [NW-1:0] node_next_mem [NODE_COUNT];
  logic [15:0] node_waiter_mem [NODE_COUNT];
  logic [SW-1:0] fslot_mem [SLOT_COUNT];
  logic [NW-1:0] fnode_mem [NODE_COUNT];
  logic [SCW-1:0] fslot_top_r, fresh_slot_r;
  logic [NCW-1:0] fnode_top_r, fresh_node_r;

  logic [2:0] act_r;
  logic [3:0] tslot_r;
  logic [15:0] tgen_r, wid_r;
  logic [NW-1:0] walk_node_r;
  logic [5:0] walk_left_r, walk_cnt_r;

  logic [SW-1:0] sidx;
  logic [GEN_BITS-1:0] cur_gen, gen_inc;
  logic [SW-1:0] new_slot;
  logic [NW-1:0] new_node;

  assign sidx = SW'(tslot_r);
  assign cur_gen = gen_touched_r[sidx] ? gen_r[sidx] : GEN_BITS'(1);
  assign gen_inc = (cur_gen + GEN_BITS'(1) == '0) ? GEN_BITS'(1) : cur_gen + GEN_BITS'(1);
  assign new_slot = (fslot_top_r != '0) ? fslot_mem[SW'(fslot_top_r - SCW'(1))]
                                         : fresh_slot_r[SW-1:0];
  assign new_node = (fnode_top_r != '0) ? fnode_mem[NW'(fnode_top_r - NCW'(1))]
                                         : fresh_node_r[NW-1:0];

  always_comb begin
    stat.action = act_r;
    stat.token_ok = (tgen_r != '0) && (32'(tslot_r) < SLOT_COUNT) && in_use_r[sidx]
      && (32'(cur_gen) == 32'(tgen_r));
    stat.slot_ready = ready_r[sidx];
    stat.waiters_zero = waiters_r[sidx] == '0;
    stat.waiters_full = 32'(waiters_r[sidx]) >= MAX_WAKE;
    stat.slot_avail = (fslot_top_r != '0) || (32'(fresh_slot_r) < SLOT_COUNT);
    stat.node_avail = (fnode_top_r != '0) || (32'(fresh_node_r) < NODE_COUNT);
    stat.walk_last = walk_left_r == 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      in_use_r <= '0;
      ready_r <= '0;
      gen_touched_r <= '0;
      fslot_top_r <= '0;
      fresh_slot_r <= '0;
      fnode_top_r <= '0;
      fresh_node_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        waiters_r[i] <= '0;
      end
    end else begin
      out_valid <= cmd.emit_single || (cmd.walk_free && cmd.walk_emit);
      if (cmd.load) begin
        act_r <= in_action;
        tslot_r <= in_token_slot;
        tgen_r <= in_token_generation;
        wid_r <= in_waiter_id;
      end
      if (cmd.emit_single) begin
        out_status <= cmd.emit_status;
        out_slot <= cmd.do_acquire ? 4'(new_slot) : '0;
        out_generation <= cmd.do_acquire ?
          16'(gen_touched_r[new_slot] ? gen_r[new_slot] : GEN_BITS'(1)) : '0;
        out_woken_id <= '0;
        out_woken_valid <= 1'b0;
        out_woken_count <= '0;
        out_last <= 1'b1;
      end
      if (cmd.do_acquire) begin
        in_use_r[new_slot] <= 1'b1;
        ready_r[new_slot] <= 1'b0;
        waiters_r[new_slot] <= '0;
        if (fslot_top_r != '0) fslot_top_r <= fslot_top_r - SCW'(1);
        else fresh_slot_r <= fresh_slot_r + SCW'(1);
      end
      if (cmd.do_park) begin
        node_next_mem[new_node] <= '0;
        node_waiter_mem[new_node] <= wid_r;
        if (waiters_r[sidx] == '0) head_r[sidx] <= new_node;
        else node_next_mem[tail_r[sidx]] <= new_node;
        tail_r[sidx] <= new_node;
        waiters_r[sidx] <= waiters_r[sidx] + 6'd1;
        if (fnode_top_r != '0) fnode_top_r <= fnode_top_r - NCW'(1);
        else fresh_node_r <= fresh_node_r + NCW'(1);
      end
      if (cmd.do_unpark_head) begin
        ready_r[sidx] <= 1'b1;
        walk_node_r <= head_r[sidx];
        walk_left_r <= waiters_r[sidx];
        walk_cnt_r <= waiters_r[sidx];
      end
      if (cmd.do_not_ready) ready_r[sidx] <= 1'b0;
      if (cmd.do_release_slot) begin
        in_use_r[sidx] <= 1'b0;
        ready_r[sidx] <= 1'b0;
        gen_r[sidx] <= gen_inc;
        gen_touched_r[sidx] <= 1'b1;
        walk_node_r <= head_r[sidx];
        walk_left_r <= waiters_r[sidx];
        if (32'(fslot_top_r) < SLOT_COUNT) begin
          fslot_mem[SW'(fslot_top_r)] <= sidx;
          fslot_top_r <= fslot_top_r + SCW'(1);
        end
      end
      if (cmd.walk_free) begin
        walk_node_r <= node_next_mem[walk_node_r];
        walk_left_r <= walk_left_r - 6'd1;
        if (32'(fnode_top_r) < NODE_COUNT) begin
          fnode_mem[NW'(fnode_top_r)] <= walk_node_r;
          fnode_top_r <= fnode_top_r + NCW'(1);
        end
        if (cmd.walk_emit) begin
          out_status <= ST_OK;
          out_slot <= '0;
          out_generation <= '0;
          out_woken_id <= node_waiter_mem[walk_node_r];
          out_woken_valid <= 1'b1;
          out_woken_count <= walk_cnt_r;
          out_last <= walk_left_r == 6'd1;
        end
      end
      if (cmd.walk_done) waiters_r[sidx] <= '0;
    end
  end
endmodule

// ----- hw/rtl/wet_ctrl.sv -----
// Controller state machine of the wait event table.
module wet_ctrl import wet_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  wet_stat_t stat,
  output wet_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_WAKE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign busy = state_r != S_IDLE;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        if (stat.action == ACT_ACQUIRE) begin
          if (stat.slot_avail) begin
            cmd.do_acquire = 1'b1;
            cmd.emit_single = 1'b1;
            cmd.emit_status = ST_OK;
          end else begin
            cmd.emit_single = 1'b1;
            cmd.emit_status = ST_NO_SLOT;
          end
        end else if (stat.action > ACT_NOT_READY) begin
          cmd.emit_single = 1'b1;
        end else if (!stat.token_ok) begin
          cmd.emit_single = 1'b1;
          cmd.emit_status = ST_BAD_TOKEN;
        end else begin
          case (stat.action)
            ACT_RELEASE: begin
              cmd.do_release_slot = 1'b1;
              cmd.emit_single = 1'b1;
              if (!stat.waiters_zero) state_nxt = S_FREE;
              else cmd.walk_done = 1'b1;
            end
            ACT_PARK: begin
              cmd.emit_single = 1'b1;
              if (stat.slot_ready) cmd.emit_status = ST_READY;
              else if (stat.waiters_full || !stat.node_avail) cmd.emit_status = ST_NO_NODE;
              else cmd.do_park = 1'b1;
            end
            ACT_UNPARK: begin
              cmd.do_unpark_head = 1'b1;
              if (stat.waiters_zero) cmd.emit_single = 1'b1;
              else state_nxt = S_WAKE;
            end
            default: begin
              cmd.do_not_ready = 1'b1;
              cmd.emit_single = 1'b1;
            end
          endcase
        end
      end
      S_FREE: begin
        cmd.walk_free = 1'b1;
        if (stat.walk_last) begin
          cmd.walk_done = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_WAKE: begin
        cmd.walk_free = 1'b1;
        cmd.walk_emit = 1'b1;
        if (stat.walk_last) begin
          cmd.walk_done = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ----- hw/rtl/wet_checker.sv -----
// Port checker of the wait event table, bound to the top level.
`include "assert_macros.svh"
module wet_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_woken_valid,
  input logic [15:0] out_woken_id,
  input logic [5:0] out_woken_count,
  input logic out_last
);
  `AST_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not raised after transfer")
  `AST_IMPL(a_out_busy, clk, rst_n, out_valid, busy, "result while idle")
  `AST_IMPL(a_wcount, clk, rst_n, out_valid && out_woken_valid, out_woken_count != '0, "no count")
  `AST_IMPL(a_empty_last, clk, rst_n, out_valid && !out_woken_valid, out_last, "no last")
  `AST_IMPL(a_empty_id, clk, rst_n, out_valid && !out_woken_valid, out_woken_id == '0, "stray id")
endmodule

bind wait_event_table_unit wet_checker u_wet_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_woken_valid(out_woken_valid), .out_woken_id(out_woken_id),
  .out_woken_count(out_woken_count), .out_last(out_last)
);
